// ===== hw/rtl/roes_pkg.sv =====
`timescale 1ns / 1ps

package roes_pkg;

    // Register map (index in the register list)
    localparam logic [0:0] REG_ACTIVE_RANGES = 1'b0;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Largest byte offset a request can reach
    localparam logic [63:0] OFFSET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // One range table word
    typedef struct packed {
        logic [62:0] start;
        logic [62:0] length;
        logic [3:0]  owner;
    } range_entry_t;

    // Table word entering the overlap pipeline
    typedef struct packed {
        logic         valid;
        logic         owner_ok;
        range_entry_t entry;
    } scan_beat_t;

    // Overlap result leaving the overlap pipeline
    typedef struct packed {
        logic        hit;
        logic [3:0]  owner;
        logic [63:0] ov;
    } ov_beat_t;

endpackage

// ===== hw/rtl/roes_req_if.sv =====
`timescale 1ns / 1ps

interface roes_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [5:0]         entry_index;
    logic [62:0]        range_start;
    logic [62:0]        range_length;
    logic [3:0]         range_endpoint;
    logic signed [63:0] query_offset;
    logic signed [63:0] query_length;

    modport source
    (
        output valid, req_type, entry_index, range_start, range_length,
               range_endpoint, query_offset, query_length,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, entry_index, range_start, range_length,
               range_endpoint, query_offset, query_length,
        output ready
    );
endinterface

// ===== hw/rtl/roes_rsp_if.sv =====
`timescale 1ns / 1ps

interface roes_rsp_if;
    logic        valid;
    logic        ready;
    logic        endpoint_found;
    logic [3:0]  best_endpoint;
    logic [63:0] best_overlap;

    modport source
    (
        output valid, endpoint_found, best_endpoint, best_overlap,
        input  ready
    );

    modport sink
    (
        input  valid, endpoint_found, best_endpoint, best_overlap,
        output ready
    );
endinterface

// ===== hw/rtl/roes_overlap_calc.sv =====
`timescale 1ns / 1ps

// Three-stage overlap of one table range with the current request.
module roes_overlap_calc
(
    input  logic                clk,
    input  logic                rst_n,
    input  roes_pkg::scan_beat_t scan,
    input  logic [63:0]         q_off,
    input  logic [63:0]         q_end,
    output roes_pkg::ov_beat_t  beat,
    output logic                busy
);
    import roes_pkg::*;

    logic        b_valid_reg, c_valid_reg, d_valid_reg;
    logic        b_ok_reg, c_ok_reg, d_hit_reg;
    logic [3:0]  b_owner_reg, c_owner_reg, d_owner_reg;
    logic [63:0] b_re_reg, b_lo_reg, c_lo_reg, c_hi_reg, d_ov_reg;

    logic [63:0] rs_ext, rl_ext, re_next, lo_next, hi_next, ov_next;
    logic        ok_next, hit_next;

    // Stage B: range end and lower bound
    always_comb
    begin
        rs_ext  = {1'b0, scan.entry.start};
        rl_ext  = {1'b0, scan.entry.length};
        re_next = rs_ext + rl_ext - 64'd1;
        lo_next = (q_off > rs_ext) ? q_off : rs_ext;
        ok_next = scan.owner_ok && (scan.entry.length != 63'd0);
    end

    // Stage C: upper bound
    assign hi_next = (q_end < b_re_reg) ? q_end : b_re_reg;

    // Stage D: overlap length
    assign hit_next = c_ok_reg && (c_lo_reg <= c_hi_reg);
    assign ov_next  = c_hi_reg - c_lo_reg + 64'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= scan.valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_ok_reg    <= ok_next;
        b_owner_reg <= scan.entry.owner;
        b_re_reg    <= re_next;
        b_lo_reg    <= lo_next;

        c_ok_reg    <= b_ok_reg;
        c_owner_reg <= b_owner_reg;
        c_lo_reg    <= b_lo_reg;
        c_hi_reg    <= hi_next;

        d_hit_reg   <= hit_next;
        d_owner_reg <= c_owner_reg;
        d_ov_reg    <= ov_next;
    end

    assign beat.hit   = d_valid_reg && d_hit_reg;
    assign beat.owner = d_owner_reg;
    assign beat.ov    = d_ov_reg;
    assign busy       = b_valid_reg || c_valid_reg || d_valid_reg;

endmodule

// ===== hw/rtl/range_overlap_endpoint_select_core.sv =====
`timescale 1ns / 1ps

// Range write: one per cycle while idle. Invalid query: no scan, result goes via the done state.
// Valid query: min(active_ranges, MAX_RANGES) entries are read through the single read port
// of the range table (one entry per cycle), the overlap and accumulate pipeline drains, then
// the sum memory is swept.
// One query in flight at a time; a result waits in the output register without blocking writes.
// Reset (async, active low) clears control state and active_ranges; the range table is
// undefined until written and endpoint sums are cleared through valid bits at each query.
module range_overlap_endpoint_select_core
#(
    parameter int MAX_RANGES    = 64,
    parameter int NUM_ENDPOINTS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    roes_req_if.sink     req,
    roes_rsp_if.source   rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import roes_pkg::*;

    localparam int RIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W  = $clog2(MAX_RANGES + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int EIDX_W = $clog2(NUM_ENDPOINTS);
    localparam int EC_W   = $clog2(NUM_ENDPOINTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [6:0]          active_reg;

    // query context
    logic [63:0]         q_off_reg, q_end_reg;
    logic [CNT_W-1:0]    scan_count_reg, scan_idx_reg;

    // range table
    range_entry_t        tbl_mem [MAX_RANGES];
    range_entry_t        tbl_rdata_reg, wr_entry;
    logic                rd_valid_reg;
    logic                tbl_we;
    logic [RIDX_W-1:0]   tbl_waddr, tbl_raddr;

    // endpoint sums
    logic [63:0]         sum_mem [NUM_ENDPOINTS];
    logic [63:0]         sum_rdata_reg;
    logic [NUM_ENDPOINTS-1:0] sum_valid_reg;
    logic [EIDX_W-1:0]   sum_raddr;

    // accumulate stage and write forwarding
    logic                acc_valid_reg, lastw_valid_reg;
    logic [EIDX_W-1:0]   acc_addr_reg, lastw_addr_reg;
    logic [63:0]         acc_ov_reg, lastw_data_reg;
    logic [63:0]         acc_base, acc_sum;
    logic [64:0]         acc_wide;

    // best search
    logic [EC_W-1:0]     find_idx_reg;
    logic                fv_reg;
    logic [EIDX_W-1:0]   fidx_reg;
    logic [63:0]         best_sum_reg, find_val;
    logic [EIDX_W-1:0]   best_ep_reg;

    // output register
    logic                out_valid_reg, out_found_reg;
    logic [3:0]          out_ep_reg;
    logic [63:0]         out_ov_reg;

    scan_beat_t          scan;
    ov_beat_t            beat;
    logic                calc_busy;

    logic                in_beat, query_beat, query_bad, out_free;
    logic                issue_rd, issue_find, scan_done, find_done;
    logic [63:0]         len_u, off_u, end_sum, end_next;
    logic [CNT_W-1:0]    count_next;
    logic [CMP_W-1:0]    act_ext, max_ext, idx_ext;
    logic [8:0]          owner_ext;
    logic                cfg_we;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_RANGES);
    assign prdata = (paddr[2] == REG_ACTIVE_RANGES) ? {25'd0, active_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 7'd0;
        else if (cfg_we)
            active_reg <= pwdata[6:0];
    end

    // input decode
    assign req.ready  = (state_reg == ST_IDLE);
    assign in_beat    = req.valid && req.ready;
    assign query_beat = in_beat && (req.req_type == REQ_QUERY);
    assign off_u      = $unsigned(req.query_offset);
    assign len_u      = $unsigned(req.query_length);
    assign query_bad  = off_u[63] || len_u[63] || (len_u == 64'd0);
    assign end_sum    = off_u + len_u - 64'd1;
    assign end_next   = end_sum[63] ? OFFSET_MAX : end_sum;

    always_comb
    begin
        act_ext    = CMP_W'(active_reg);
        max_ext    = CMP_W'(MAX_RANGES);
        count_next = (act_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(act_ext);
        idx_ext    = CMP_W'(req.entry_index);
    end

    // range table write and scan read
    assign tbl_we    = in_beat && (req.req_type == REQ_WRITE) && (idx_ext < max_ext);
    assign tbl_waddr = RIDX_W'(req.entry_index);
    assign wr_entry  = '{start: req.range_start, length: req.range_length,
                         owner: req.range_endpoint};
    assign issue_rd  = (state_reg == ST_SCAN) && (scan_idx_reg < scan_count_reg);
    assign tbl_raddr = scan_idx_reg[RIDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= wr_entry;
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    assign owner_ext     = 9'(tbl_rdata_reg.owner);
    assign scan.valid    = rd_valid_reg;
    assign scan.owner_ok = owner_ext < 9'(NUM_ENDPOINTS);
    assign scan.entry    = tbl_rdata_reg;

    roes_overlap_calc u_calc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan),
        .q_off (q_off_reg),
        .q_end (q_end_reg),
        .beat  (beat),
        .busy  (calc_busy)
    );

    // sum memory read: accumulate during scan, sweep during search
    assign issue_find = (state_reg == ST_FIND) && (find_idx_reg < EC_W'(NUM_ENDPOINTS));
    always_comb
    begin
        if (state_reg == ST_FIND)
            sum_raddr = find_idx_reg[EIDX_W-1:0];
        else if (beat.hit)
            sum_raddr = EIDX_W'(beat.owner);
        else
            sum_raddr = '0;
    end

    // saturating add, forwarded from the write of the previous cycle
    always_comb
    begin
        if (lastw_valid_reg && (lastw_addr_reg == acc_addr_reg))
            acc_base = lastw_data_reg;
        else if (sum_valid_reg[acc_addr_reg])
            acc_base = sum_rdata_reg;
        else
            acc_base = 64'd0;
        acc_wide = {1'b0, acc_base} + {1'b0, acc_ov_reg};
        acc_sum  = acc_wide[64] ? {64{1'b1}} : acc_wide[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (acc_valid_reg)
            sum_mem[acc_addr_reg] <= acc_sum;
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    assign find_val = sum_valid_reg[fidx_reg] ? sum_rdata_reg : 64'd0;

    // phase completion
    assign scan_done = (scan_idx_reg == scan_count_reg) && !rd_valid_reg && !calc_busy
                       && !acc_valid_reg;
    assign find_done = (find_idx_reg == EC_W'(NUM_ENDPOINTS)) && !fv_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_beat)
                    state_next = query_bad ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (find_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_valid_reg    <= 1'b0;
            acc_valid_reg   <= 1'b0;
            lastw_valid_reg <= 1'b0;
            sum_valid_reg   <= '0;
            fv_reg          <= 1'b0;
            scan_idx_reg    <= '0;
            scan_count_reg  <= '0;
            find_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_valid_reg    <= issue_rd;
            acc_valid_reg   <= beat.hit;
            lastw_valid_reg <= acc_valid_reg;
            fv_reg          <= issue_find;

            if (query_beat)
            begin
                sum_valid_reg  <= '0;
                scan_idx_reg   <= '0;
                scan_count_reg <= count_next;
            end
            else
            begin
                if (acc_valid_reg)
                    sum_valid_reg[acc_addr_reg] <= 1'b1;
                if (issue_rd)
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end

            if (state_reg == ST_SCAN)
                find_idx_reg <= '0;
            else if (issue_find)
                find_idx_reg <= find_idx_reg + EC_W'(1);

            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (query_beat)
        begin
            q_off_reg    <= off_u;
            q_end_reg    <= end_next;
            best_sum_reg <= 64'd0;
            best_ep_reg  <= '0;
        end
        else if (fv_reg && (find_val > best_sum_reg))
        begin
            best_sum_reg <= find_val;
            best_ep_reg  <= fidx_reg;
        end

        acc_addr_reg   <= EIDX_W'(beat.owner);
        acc_ov_reg     <= beat.ov;
        lastw_addr_reg <= acc_addr_reg;
        lastw_data_reg <= acc_sum;
        fidx_reg       <= find_idx_reg[EIDX_W-1:0];

        if ((state_reg == ST_DONE) && out_free)
        begin
            out_found_reg <= (best_sum_reg != 64'd0);
            out_ep_reg    <= 4'(best_ep_reg);
            out_ov_reg    <= best_sum_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.endpoint_found = out_found_reg;
    assign rsp.best_endpoint  = out_ep_reg;
    assign rsp.best_overlap   = out_ov_reg;

endmodule

// ===== test/range_overlap_endpoint_select_core_test.sv =====
`timescale 1ns / 1ps

module range_overlap_endpoint_select_core_test;

    import roes_pkg::*;

    localparam int SLOTS     = 64;
    localparam int ENDPOINTS = 16;
    // Slot pitch of the sorted table layout used by the random part
    localparam int PITCH     = 80;
    // Longest scan plus some margin, in cycles
    localparam int SETTLE_CYCLES = 120;

    localparam logic [2:0] ACTIVE_ADDR   = {REG_ACTIVE_RANGES, 2'b00};
    // Address of register index 1, which does not exist
    localparam logic [2:0] UNMAPPED_ADDR = 3'b100;

    typedef struct packed {
        bit        settle;
        bit        req_type;
        bit [5:0]  entry_index;
        bit [62:0] range_start;
        bit [62:0] range_length;
        bit [3:0]  range_endpoint;
        bit [63:0] query_offset;
        bit [63:0] query_length;
    } req_item_t;

    typedef struct packed {
        bit        found;
        bit [3:0]  endpoint;
        bit [63:0] overlap;
    } pick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    roes_req_if req_bus();
    roes_rsp_if rsp_bus();

    range_overlap_endpoint_select_core
    #(
        .MAX_RANGES    (SLOTS),
        .NUM_ENDPOINTS (ENDPOINTS)
    )
    DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the range table and the register
    bit [62:0] tbl_start [SLOTS];
    bit [62:0] tbl_len   [SLOTS];
    bit [3:0]  tbl_owner [SLOTS];
    bit [6:0]  active_cfg;

    req_item_t   pend_q [$];
    pick_t       picks_q [$];
    req_item_t   drive_item;
    pick_t       want;
    int unsigned issued;
    int unsigned accepted;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned errors;
    bit          sender_idle_en;
    bit          sink_idle_en;
    int          phase_active [7] = '{64, 127, 1, 0, -1, 127, -1};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Endpoint with the largest summed overlap for one query
    function automatic pick_t pick_endpoint(bit [63:0] off, bit [63:0] len);
        bit [63:0] sums [ENDPOINTS];
        bit [63:0] req_end;
        bit [63:0] rs;
        bit [63:0] re;
        bit [63:0] lo;
        bit [63:0] hi;
        bit [64:0] acc;
        int        n;
        int        i;
        pick_t     p;
        p = '0;
        foreach (sums[e])
            sums[e] = '0;
        if (off[63] || len[63] || len == 64'd0)
            return p;
        // both below 2^63, so the end cannot wrap
        req_end = off + len - 64'd1;
        if (req_end > OFFSET_MAX)
            req_end = OFFSET_MAX;
        n = (int'(active_cfg) > SLOTS) ? SLOTS : int'(active_cfg);
        for (i = 0; i < n; i++)
        begin
            if (tbl_len[i] == 63'd0)
                continue;
            rs = {1'b0, tbl_start[i]};
            re = rs + {1'b0, tbl_len[i]} - 64'd1;
            lo = (off > rs) ? off : rs;
            hi = (req_end < re) ? req_end : re;
            if (lo > hi)
                continue;
            // saturating add
            acc = {1'b0, sums[tbl_owner[i]]} + {1'b0, hi - lo + 64'd1};
            sums[tbl_owner[i]] = acc[64] ? '1 : acc[63:0];
        end
        for (i = 0; i < ENDPOINTS; i++)
        begin
            if (sums[i] > p.overlap)
            begin
                p.overlap  = sums[i];
                p.endpoint = 4'(i);
            end
        end
        p.found = (p.overlap != 64'd0);
        return p;
    endfunction

    function automatic req_item_t range_write_item(bit [5:0] idx, bit [62:0] start,
                                                   bit [62:0] len, bit [3:0] owner);
        req_item_t it;
        it = '0;
        it.req_type       = REQ_WRITE;
        it.entry_index    = idx;
        it.range_start    = start;
        it.range_length   = len;
        it.range_endpoint = owner;
        return it;
    endfunction

    function automatic req_item_t query_item(bit [63:0] off, bit [63:0] len);
        req_item_t it;
        it = '0;
        it.req_type     = REQ_QUERY;
        it.query_offset = off;
        it.query_length = len;
        return it;
    endfunction

    // Mostly writes that keep the table sorted and windowed queries,
    // the rest full-width noise, huge and invalid requests
    function automatic req_item_t random_item();
        req_item_t   it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            it = range_write_item(6'($urandom_range(0, SLOTS - 1)), '0, '0,
                                  4'($urandom_range(0, ENDPOINTS - 1)));
            if (pick < 24)
            begin
                it.range_start  = 63'(it.entry_index * PITCH + $urandom_range(0, 16));
                it.range_length = 63'($urandom_range(1, 64));
            end
            else
            begin
                it.range_start  = 63'({$urandom, $urandom});
                it.range_length = 63'({$urandom, $urandom});
            end
        end
        else if (pick < 80)
            it = query_item(64'($urandom_range(0, SLOTS * PITCH + 200)),
                            64'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 2000 : 300)));
        else if (pick < 88)
            it = query_item({$urandom, $urandom} >> 1,
                            {$urandom, $urandom} >> $urandom_range(1, 40));
        else if (pick < 96)
            it = query_item({$urandom, $urandom}, {$urandom, $urandom});
        else
            it = query_item({$urandom, $urandom}, 64'd0);
        it.settle = ($urandom_range(0, 49) == 0);
        return it;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
        errors++;
    endtask

    // Update the table, or queue the pick for a query
    task automatic absorb_request();
        int unsigned slot;
        if (req_bus.req_type == REQ_WRITE)
        begin
            slot = 32'(req_bus.entry_index);
            tbl_start[slot] = req_bus.range_start;
            tbl_len[slot]   = req_bus.range_length;
            tbl_owner[slot] = req_bus.range_endpoint;
        end
        else
            picks_q.push_back(pick_endpoint(req_bus.query_offset, req_bus.query_length));
    endtask

    // One APB transfer; a read is checked against the register copy
    task automatic cfg_access(bit is_write, logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (is_write && addr == ACTIVE_ADDR)
            active_cfg = data[6:0];
        if (!is_write && prdata !== {25'd0, active_cfg})
            note_mismatch("active_ranges readback", 64'(prdata), 64'({25'd0, active_cfg}));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Block until nothing is queued, in flight or expected, then let a scan finish
    task automatic wait_quiet();
        while (pend_q.size() != 0 || issued != accepted || picks_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_active(int unsigned value);
        wait_quiet();
        cfg_access(1'b1, ACTIVE_ADDR, value);
        cfg_access(1'b0, ACTIVE_ADDR, 32'd0);
    endtask

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (issued == accepted)
        begin
            if (gap_left != 0)
            begin
                req_bus.valid <= 1'b0;
                gap_left--;
            end
            else if (pend_q.size() != 0 && !(pend_q[0].settle && picks_q.size() != 0))
            begin
                drive_item = pend_q.pop_front();
                req_bus.valid          <= 1'b1;
                req_bus.req_type       <= drive_item.req_type;
                req_bus.entry_index    <= drive_item.entry_index;
                req_bus.range_start    <= drive_item.range_start;
                req_bus.range_length   <= drive_item.range_length;
                req_bus.range_endpoint <= drive_item.range_endpoint;
                req_bus.query_offset   <= drive_item.query_offset;
                req_bus.query_length   <= drive_item.query_length;
                issued++;
                gap_left = sender_idle_en ? idle_span() : 0;
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            if (sink_idle_en)
                stall_left = idle_span();
        end
    end

    // Monitor: results checked first, so a beat never matches its own query
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (picks_q.size() == 0)
                    note_mismatch("unexpected result beat", rsp_bus.best_overlap, 64'd0);
                else
                begin
                    want = picks_q.pop_front();
                    if (rsp_bus.endpoint_found !== want.found)
                        note_mismatch("endpoint_found", 64'(rsp_bus.endpoint_found),
                                      64'(want.found));
                    if (rsp_bus.best_endpoint !== want.endpoint)
                        note_mismatch("best_endpoint", 64'(rsp_bus.best_endpoint),
                                      64'(want.endpoint));
                    if (rsp_bus.best_overlap !== want.overlap)
                        note_mismatch("best_overlap", rsp_bus.best_overlap, want.overlap);
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                accepted++;
                absorb_request();
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("range_overlap_endpoint_select_core_test: done, errors");
        $finish;
    end

    initial
    begin
        req_bus.valid          = 1'b0;
        req_bus.req_type       = REQ_WRITE;
        req_bus.entry_index    = '0;
        req_bus.range_start    = '0;
        req_bus.range_length   = '0;
        req_bus.range_endpoint = '0;
        req_bus.query_offset   = '0;
        req_bus.query_length   = '0;
        rsp_bus.ready          = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        active_cfg             = '0;
        sender_idle_en         = 1'b1;
        sink_idle_en           = 1'b1;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Register: zero, then a write to a missing register must not land
        cfg_access(1'b1, ACTIVE_ADDR, 32'd0);
        cfg_access(1'b0, ACTIVE_ADDR, 32'd0);
        cfg_access(1'b1, UNMAPPED_ADDR, 32'h7F);
        cfg_access(1'b0, ACTIVE_ADDR, 32'd0);

        // Empty table: a query finds nothing; then load the directed table
        pend_q.push_back(query_item(64'd0, 64'd1));
        pend_q.push_back(range_write_item(6'd0, 63'd0, 63'd100, 4'd3));
        pend_q.push_back(range_write_item(6'd1, 63'd100, 63'd50, 4'd15));
        // zero-length slot
        pend_q.push_back(range_write_item(6'd2, 63'd150, 63'd0, 4'd0));
        pend_q.push_back(range_write_item(6'd3, 63'd200, 63'd100, 4'd7));
        pend_q.push_back(range_write_item(6'd4, 63'd300, 63'd100, 4'd2));
        // three huge overlapping ranges of one endpoint, their sum saturates
        pend_q.push_back(range_write_item(6'd5, 63'd0, OFFSET_MAX[62:0], 4'd9));
        pend_q.push_back(range_write_item(6'd6, 63'd1, OFFSET_MAX[62:0], 4'd9));
        pend_q.push_back(range_write_item(6'd7, 63'd5, OFFSET_MAX[62:0], 4'd9));
        pend_q.push_back(range_write_item(6'd63, OFFSET_MAX[62:0], OFFSET_MAX[62:0], 4'd15));

        set_active(5);
        // three-way tie, lowest endpoint wins
        pend_q.push_back(query_item(64'd0, 64'd400));
        pend_q.push_back(query_item('1, 64'd10));
        pend_q.push_back(query_item(64'd0, 64'd0));
        pend_q.push_back(query_item(64'd0, '1));
        pend_q.push_back(query_item(64'h8000_0000_0000_0000, OFFSET_MAX));
        pend_q.push_back(query_item(OFFSET_MAX, 64'h8000_0000_0000_0000));
        // saturated request end, nothing that far up
        pend_q.push_back(query_item(OFFSET_MAX, OFFSET_MAX));
        pend_q.push_back(query_item(64'd120, 64'd10));
        // only the zero-length slot lies here
        pend_q.push_back(query_item(64'd150, 64'd50));

        set_active(8);
        pend_q.push_back(query_item(64'd0, OFFSET_MAX));
        pend_q.push_back(query_item(64'd0, 64'd1));
        pend_q.push_back(query_item(OFFSET_MAX, 64'd1));

        // Fill every slot with a sorted, non-overlapping layout
        wait_quiet();
        sender_idle_en = 1'($urandom_range(0, 1));
        for (int s = 0; s < SLOTS; s++)
            pend_q.push_back(range_write_item(6'(s), 63'(s * PITCH + $urandom_range(0, 16)),
                                              63'($urandom_range(1, 64)),
                                              4'($urandom_range(0, ENDPOINTS - 1))));

        // Random phases, each under its own register setting
        foreach (phase_active[ph])
        begin
            set_active((phase_active[ph] < 0) ? $urandom_range(0, 127) : phase_active[ph]);
            sender_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en   = ($urandom_range(0, 3) != 0);
            repeat (60)
                pend_q.push_back(random_item());
        end

        wait_quiet();
        if (errors == 0)
            $display("range_overlap_endpoint_select_core_test: done, clean");
        else
            $display("range_overlap_endpoint_select_core_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/roes_pkg.sv
hw/rtl/roes_req_if.sv
hw/rtl/roes_rsp_if.sv
hw/rtl/roes_overlap_calc.sv
hw/rtl/range_overlap_endpoint_select_core.sv
test/range_overlap_endpoint_select_core_test.sv
